// File: rtl/upc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_pkg
// Types, constants and helper functions shared by the percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam int unsigned GrpDepth = 3;
    localparam int unsigned CntW     = 2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DIRECTION   = 2'd0;
    localparam logic [1:0] REG_EXTRA_EN    = 2'd1;
    localparam logic [1:0] REG_EXTRA_CHAR  = 2'd2;

    localparam logic       DIR_ENCODE      = 1'b0;
    localparam logic       DIR_DECODE      = 1'b1;
    localparam logic [7:0] EXTRA_CHAR_RST  = 8'd47;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_STAR    = 8'h2A;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_HIGH    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       bad_escape;
    } t_out_item;

    typedef struct packed {
        logic [CntW-1:0]             count;
        t_out_item [GrpDepth-1:0]    item;
    } t_result_grp;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h41 + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

    // {digit valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_MINUS || c == CH_USCORE ||
               c == CH_DOT || c == CH_STAR;
    endfunction

endpackage

// File: rtl/upc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_core
// Configuration registers, escape state and the per-byte codec logic.
// ----------------------------------------------------------------------------
module upc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_take,
    input  upc_pkg::t_in_item     i_item,
    output upc_pkg::t_result_grp  o_grp
);
    import upc_pkg::*;

    logic        r_direction;
    logic        r_extra_en;
    logic [7:0]  r_extra_char;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [3:0]  r_high;
    logic [3:0]  n_high;

    logic [7:0]  c;
    logic        eos;
    logic [4:0]  hv;
    logic        kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= DIR_ENCODE;
            r_extra_en   <= 1'b0;
            r_extra_char <= EXTRA_CHAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIRECTION:  r_direction  <= i_cfg_data[0];
                REG_EXTRA_EN:   r_extra_en   <= i_cfg_data[0];
                REG_EXTRA_CHAR: r_extra_char <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_high  <= 4'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_high  <= n_high;
        end
    end

    assign c    = i_item.in_byte;
    assign eos  = i_item.end_of_string;
    assign hv   = hex_value(c);
    assign kept = is_unreserved(c) || (r_extra_en && c == r_extra_char);

    always_comb begin
        o_grp   = '0;
        n_phase = r_phase;
        n_high  = r_high;
        if (r_direction == DIR_ENCODE) begin
            n_phase = PH_IDLE;
            n_high  = 4'd0;
            if (kept) begin
                o_grp.count   = CntW'(1);
                o_grp.item[0] = '{out_byte: c, last: eos, bad_escape: 1'b0};
            end else begin
                o_grp.count   = CntW'(3);
                o_grp.item[0] = '{out_byte: CH_PERCENT, last: 1'b0, bad_escape: 1'b0};
                o_grp.item[1] = '{out_byte: hex_char(c[7:4]), last: 1'b0, bad_escape: 1'b0};
                o_grp.item[2] = '{out_byte: hex_char(c[3:0]), last: eos, bad_escape: 1'b0};
            end
        end else if (r_phase == PH_PERCENT || r_phase == PH_HIGH) begin
            if (!hv[4]) begin
                // drop the escape on a non-hex digit
                n_phase       = PH_IDLE;
                n_high        = 4'd0;
                o_grp.count   = CntW'(1);
                o_grp.item[0] = '{out_byte: 8'd0, last: eos, bad_escape: 1'b1};
            end else if (r_phase == PH_PERCENT) begin
                if (eos) begin
                    n_phase       = PH_IDLE;
                    n_high        = 4'd0;
                    o_grp.count   = CntW'(1);
                    o_grp.item[0] = '{out_byte: 8'd0, last: 1'b1, bad_escape: 1'b1};
                end else begin
                    n_phase = PH_HIGH;
                    n_high  = hv[3:0];
                end
            end else begin
                n_phase       = PH_IDLE;
                n_high        = 4'd0;
                o_grp.count   = CntW'(1);
                o_grp.item[0] = '{out_byte: {r_high, hv[3:0]}, last: eos, bad_escape: 1'b0};
            end
        end else begin
            n_phase = PH_IDLE;
            if (c == CH_PERCENT) begin
                if (eos) begin
                    n_high        = 4'd0;
                    o_grp.count   = CntW'(1);
                    o_grp.item[0] = '{out_byte: 8'd0, last: 1'b1, bad_escape: 1'b1};
                end else begin
                    n_phase = PH_PERCENT;
                end
            end else begin
                o_grp.count   = CntW'(1);
                o_grp.item[0] = '{out_byte: (c == CH_PLUS) ? CH_SPACE : c, last: eos,
                                  bad_escape: 1'b0};
            end
        end
    end

endmodule

// File: rtl/upc_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_serializer
// Result register that holds one group of up to three items and sends them
// out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module upc_serializer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  upc_pkg::t_result_grp  i_grp,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output upc_pkg::t_out_item    o_out
);
    import upc_pkg::*;

    logic [CntW-1:0]          r_cnt;
    logic [CntW-1:0]          r_idx;
    t_out_item [GrpDepth-1:0] r_item;
    logic                     take;

    assign o_out_valid = (r_cnt != '0);
    assign take        = o_out_valid && i_out_ready;
    // free when empty or the last held item leaves this cycle
    assign o_free      = (r_cnt == '0) || (r_cnt == CntW'(1) && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_grp.count;
            r_idx <= '0;
        end else if (take) begin
            r_cnt <= r_cnt - CntW'(1);
            r_idx <= r_idx + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_grp.item;
        end
    end

    always_comb begin
        case (r_idx)
            CntW'(0): o_out = r_item[0];
            CntW'(1): o_out = r_item[1];
            CntW'(2): o_out = r_item[2];
            default:  o_out = r_item[0];
        endcase
    end

endmodule

// File: rtl/url_percent_codec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_codec_unit
// Percent-encoding and decoding of a byte stream.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one byte and an end of
// string flag. Output channel (o_out_valid / i_out_ready) carries one
// produced byte with last and bad_escape flags. Configuration writes come on
// i_cfg_valid / o_cfg_ready with a register index and data; ready is always
// high and writes are meant to be made while the block is idle.
// An accepted item is coded in the cycle it is taken and its results show
// on the output in the next cycle, one per cycle while the receiver is ready.
// Throughput: one item per cycle while the receiver is ready and each gives
// at most one result; an encoded escape gives three results, so such an
// item occupies the result register until all three have left. The result
// register drains one byte per cycle while the receiver is ready, and is
// refilled in the cycle its last byte leaves. A decode item that only advances
// an escape gives no result and is taken without occupying the output.
// Reset (synchronous, active low) empties the result register, clears the
// escape state and sets encode mode with '/' as the disabled extra byte.
// When the receiver stalls, the current result holds and the input stalls
// once the result register is full.
// ----------------------------------------------------------------------------
module url_percent_codec_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  upc_pkg::t_in_item    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output upc_pkg::t_out_item   o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import upc_pkg::*;

    t_result_grp grp;
    logic        free;
    logic        take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = free;
    assign take        = i_in_valid && free;

    upc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_item      (i_in),
        .o_grp       (grp)
    );

    upc_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_grp       (grp),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: rtl/upc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_checker
// Port-level checks for the percent codec, bound to the top level.
// ----------------------------------------------------------------------------
module upc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  upc_pkg::t_out_item   o_out
);
    import upc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result register not empty after reset");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.bad_escape |-> o_out.out_byte == 8'd0)
        else $error("error result carries a byte");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind url_percent_codec_unit upc_checker u_upc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// File: verif/url_percent_codec_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_codec_unit_tb
// Self-checking bench for the percent codec. Byte strings are pushed through
// the input channel in both coding directions. The extra kept byte is set up
// through the configuration port. An in-bench model of the coder predicts
// every output byte with its last and bad_escape flags. A scoreboard checks
// each item that leaves the block against that prediction, in order. Both
// channels idle at random, and the output is held off for long stretches so
// that the input is stalled.
// ----------------------------------------------------------------------------
module url_percent_codec_unit_tb;
    import upc_pkg::*;

    localparam int         SETTLE     = 4;
    localparam int         IDLE_LIMIT = 1000;
    localparam int         MAX_SHOWN  = 10;
    localparam logic [1:0] REG_SPARE  = 2'd3;

    typedef logic [7:0] t_byte_q[$];

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    // coder state as the bench sees it
    logic       cur_decode;
    logic       keep_extra_on;
    logic [7:0] keep_extra_byte;
    t_phase     esc_state;
    logic [3:0] esc_hi;
    t_out_item  coded_q[$];

    int n_items;
    int n_results;
    int n_cfg;
    int n_mismatch;
    int idle_cycles;
    bit tx_random;
    bit rx_random;
    int rx_hold_req;
    int rx_hold_left;
    int rx_idle_left;

    url_percent_codec_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // coder model
    // ------------------------------------------------------------------------
    function automatic logic passes_plain(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return 1'b1;
        if (c >= "0" && c <= "9") return 1'b1;
        if (c == CH_MINUS || c == CH_USCORE || c == CH_DOT || c == CH_STAR) return 1'b1;
        return keep_extra_on && c == keep_extra_byte && folded == folded;
    endfunction

    function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
        return (v > 4'd9) ? 8'h37 + {4'h0, v} : 8'h30 + {4'h0, v};
    endfunction

    // value of a hex digit in either case, -1 otherwise
    function automatic int digit_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (folded >= "a" && folded <= "f") return int'(folded) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void push_coded(input logic [7:0] b, input logic l, input logic bad);
        t_out_item r;
        r.out_byte   = b;
        r.last       = l;
        r.bad_escape = bad;
        coded_q.push_back(r);
    endfunction

    function automatic void code_byte(input t_in_item it);
        logic [7:0] c;
        logic       eos;
        int         d;
        c   = it.in_byte;
        eos = it.end_of_string;
        if (!cur_decode) begin
            // encoding drops any escape left over from decoding
            esc_state = PH_IDLE;
            esc_hi    = 4'h0;
            if (passes_plain(c)) begin
                push_coded(c, eos, 1'b0);
            end else begin
                push_coded(CH_PERCENT, 1'b0, 1'b0);
                push_coded(nibble_ascii(c[7:4]), 1'b0, 1'b0);
                push_coded(nibble_ascii(c[3:0]), eos, 1'b0);
            end
        end else if (esc_state == PH_PERCENT || esc_state == PH_HIGH) begin
            d = digit_of(c);
            if (d < 0) begin
                esc_state = PH_IDLE;
                esc_hi    = 4'h0;
                push_coded(8'h00, eos, 1'b1);
            end else if (esc_state == PH_PERCENT) begin
                if (eos) begin
                    esc_state = PH_IDLE;
                    esc_hi    = 4'h0;
                    push_coded(8'h00, 1'b1, 1'b1);
                end else begin
                    esc_state = PH_HIGH;
                    esc_hi    = d[3:0];
                end
            end else begin
                push_coded({esc_hi, d[3:0]}, eos, 1'b0);
                esc_state = PH_IDLE;
                esc_hi    = 4'h0;
            end
        end else if (c == CH_PERCENT) begin
            esc_hi = 4'h0;
            if (eos) begin
                push_coded(8'h00, 1'b1, 1'b1);
            end else begin
                esc_state = PH_PERCENT;
            end
        end else begin
            push_coded((c == CH_PLUS) ? CH_SPACE : c, eos, 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------------
    // output side: receiver and scoreboard
    // ------------------------------------------------------------------------
    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req - 1;
            rx_hold_req  = 0;
            i_out_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_idle_left > 0) begin
            rx_idle_left--;
            i_out_ready <= 1'b0;
        end else if (rx_random && $urandom_range(0, 3) == 0) begin
            rx_idle_left = idle_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void note_mismatch(input string what, input t_out_item want,
                                          input t_out_item got);
        n_mismatch++;
        if (n_mismatch <= MAX_SHOWN) begin
            $display("%0t: %s: expected byte %02h last %0b bad %0b, got byte %02h last %0b bad %0b",
                     $time, what, want.out_byte, want.last, want.bad_escape,
                     got.out_byte, got.last, got.bad_escape);
        end
    endfunction

    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (coded_q.size() == 0) begin
                note_mismatch("item with nothing pending", '0, o_out);
            end else begin
                want = coded_q.pop_front();
                if (o_out.out_byte !== want.out_byte || o_out.last !== want.last ||
                    o_out.bad_escape !== want.bad_escape) begin
                    note_mismatch("wrong item", want, o_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no item moved for %0d cycles, %0d still pending",
                         IDLE_LIMIT, coded_q.size());
                $display("url_percent_codec_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic eos);
        t_in_item it;
        int       gap;
        it.in_byte       = b;
        it.end_of_string = eos;
        gap = (tx_random && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        code_byte(it);
        n_items++;
    endtask

    task automatic send_string(input t_byte_q s);
        foreach (s[k]) send_item(s[k], k == s.size() - 1);
    endtask

    // hold the input until every pending item is out and the block has settled
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (coded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_DIRECTION:  cur_decode      = val[0];
            REG_EXTRA_EN:   keep_extra_on   = val[0];
            REG_EXTRA_CHAR: keep_extra_byte = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic [7:0] hex_glyph(input logic [3:0] v, input logic lower);
        return nibble_ascii(v) | ((lower && v > 4'd9) ? 8'h20 : 8'h00);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_glyph();
        return hex_glyph(4'($urandom), 1'($urandom));
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        c = rand_byte();
        while (digit_of(c) >= 0) c = rand_byte();
        return c;
    endfunction

    // one string of mostly well-formed tokens, some broken escapes and noise
    task automatic send_decode_string();
        t_byte_q    s;
        int         ntok;
        int         kind;
        logic [7:0] c;
        ntok = $urandom_range(1, 6);
        for (int k = 0; k < ntok; k++) begin
            kind = $urandom_range(0, 99);
            if (kind >= 94 && k == ntok - 1) begin
                // truncated escape at the end of the string
                s.push_back(CH_PERCENT);
                if ($urandom_range(0, 1)) s.push_back(rand_glyph());
            end else if (kind < 30 || kind >= 94) begin
                c = rand_byte();
                s.push_back((c == CH_PERCENT) ? CH_PLUS : c);
            end else if (kind < 40) begin
                s.push_back(CH_PLUS);
            end else if (kind < 75) begin
                s.push_back(CH_PERCENT);
                s.push_back(rand_glyph());
                s.push_back(rand_glyph());
            end else if (kind < 82) begin
                s.push_back(CH_PERCENT);
                s.push_back(non_hex());
            end else if (kind < 89) begin
                s.push_back(CH_PERCENT);
                s.push_back(rand_glyph());
                s.push_back(non_hex());
            end else begin
                s.push_back(rand_byte());
            end
        end
        send_string(s);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_encode_basics();
        t_byte_q s;
        s = '{8'h00, 8'hFF, "a", "Z", "9", CH_MINUS, CH_USCORE, CH_DOT, CH_STAR, "/"};
        send_string(s);
    endtask

    task automatic test_extra_keep();
        cfg_write(REG_EXTRA_EN, 8'h01);
        send_item("/", 1'b1);
        cfg_write(REG_EXTRA_CHAR, 8'h00);
        send_item(8'h00, 1'b0);
        send_item("/", 1'b1);
        cfg_write(REG_EXTRA_CHAR, 8'hFF);
        send_item(8'hFF, 1'b1);
        // writes to an unused index must not disturb anything
        cfg_write(REG_SPARE, 8'h00);
        send_item(8'hFF, 1'b1);
    endtask

    task automatic test_decode_basics();
        cfg_write(REG_DIRECTION, DIR_DECODE);
        send_string('{CH_PERCENT, "4", "f", CH_PLUS});
        send_string('{CH_PERCENT, "G", CH_PERCENT, "4", "Z"});
        send_string('{CH_PERCENT});
        send_string('{CH_PERCENT, "A"});
        send_string('{8'hFF, 8'h00});
    endtask

    task automatic test_backpressure();
        cfg_write(REG_DIRECTION, DIR_ENCODE);
        cfg_write(REG_EXTRA_EN, 8'h00);
        tx_random   = 1'b0;
        rx_hold_req = 80;
        repeat (24) send_item(rand_byte(), $urandom_range(0, 5) == 0);
        // pause the input until the backlog has gone
        wait_drain();
        tx_random   = 1'b1;
        rx_hold_req = 60;
        repeat (12) send_item(rand_byte(), $urandom_range(0, 5) == 0);
        wait_drain();
    endtask

    task automatic test_encode_random();
        logic [7:0] b;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin cfg_write(REG_EXTRA_EN, 8'h01); cfg_write(REG_EXTRA_CHAR, rand_byte()); end
                1: begin cfg_write(REG_EXTRA_EN, 8'h00); cfg_write(REG_EXTRA_CHAR, 8'hFF); end
                2: begin cfg_write(REG_EXTRA_EN, 8'h01); cfg_write(REG_EXTRA_CHAR, 8'h00); end
                default: begin
                    cfg_write(REG_EXTRA_EN, 8'h01);
                    cfg_write(REG_EXTRA_CHAR, CH_PERCENT);
                end
            endcase
            // one stretch with no idling on either side
            tx_random = (p != 2);
            rx_random = (p != 2);
            repeat (25) begin
                b = ($urandom_range(0, 5) == 0) ? keep_extra_byte : rand_byte();
                send_item(b, $urandom_range(0, 5) == 0);
            end
        end
        tx_random = 1'b1;
        rx_random = 1'b1;
    endtask

    task automatic test_decode_random();
        int stop_at;
        cfg_write(REG_DIRECTION, DIR_DECODE);
        cfg_write(REG_EXTRA_CHAR, rand_byte());
        for (int p = 0; p < 3; p++) begin
            tx_random = (p != 1);
            rx_random = (p != 1);
            stop_at   = n_items + 36;
            while (n_items < stop_at) send_decode_string();
            if (p == 0) begin
                // switch to encoding for five bytes and back
                cfg_write(REG_DIRECTION, DIR_ENCODE);
                repeat (5) send_item(rand_byte(), $urandom_range(0, 3) == 0);
                cfg_write(REG_DIRECTION, DIR_DECODE);
            end
        end
        tx_random = 1'b1;
        rx_random = 1'b1;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_in            <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_DIRECTION;
        i_cfg_data      <= 8'h00;
        cur_decode      = DIR_ENCODE;
        keep_extra_on   = 1'b0;
        keep_extra_byte = EXTRA_CHAR_RST;
        esc_state       = PH_IDLE;
        esc_hi          = 4'h0;
        n_items         = 0;
        n_results       = 0;
        n_cfg           = 0;
        n_mismatch      = 0;
        idle_cycles     = 0;
        tx_random       = 1'b1;
        rx_random       = 1'b1;
        rx_hold_req     = 0;
        rx_hold_left    = 0;
        rx_idle_left    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_encode_basics();
        test_extra_keep();
        test_decode_basics();
        test_backpressure();
        test_encode_random();
        test_decode_random();
        wait_drain();

        $display("sent %0d bytes and checked %0d output items over %0d register writes",
                 n_items, n_results, n_cfg);
        $display("both directions, extra byte on and off, broken escapes, long output stalls");
        if (n_mismatch == 0) begin
            $display("url_percent_codec_unit_tb OK");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("url_percent_codec_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
